FILE: rtl/sbus_frame_decoder_core_assert.svh
// assertion macros for the sbus frame decoder checker
`ifndef SBUS_FRAME_DECODER_CORE_ASSERT_SVH
`define SBUS_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication, reset masked
`define SFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbus frame decoder check failed");

// next-cycle implication, reset masked
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbus frame decoder check failed");

`endif

FILE: rtl/sfd_pkg.sv
// shared constants and types for the sbus frame decoder
`default_nettype none

package sfd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int DATA_COUNT  = 11;
    localparam int FLAGS_POS   = 23;
    localparam int CHANNELS    = 8;
    localparam int CHAN_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 5;
    localparam int DATA_IDX_W  = 4;
    localparam int CFG_INDEX_W = 8;

    localparam int FAILSAFE_BIT   = 3;
    localparam int FRAME_LOST_BIT = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE   = 8'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'h00;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CHAN_W-1:0] channel_t;
    typedef logic [POS_W-1:0]  pos_t;

endpackage

`default_nettype wire

FILE: rtl/sbus_frame_decoder_core.sv
// sbus frame decoder: frame alignment, data byte store, channel unpack
// latency: a result is registered and shown in the cycle after the flags byte transaction is accepted
// throughput: one byte per cycle, in_ready drops only while a result waits on out_ready
// the single output register holds the unpacked channels and flags
// reset: hunting, position 0, previous byte 0, registers at 0x0F and 0x00
// data byte store has no reset, every locked frame writes it before use
`default_nettype none

module sbus_frame_decoder_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire sfd_pkg::byte_t                 rx_byte,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire sfd_pkg::byte_t                 cfg_data,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output sfd_pkg::channel_t                   channel_0,
    output sfd_pkg::channel_t                   channel_1,
    output sfd_pkg::channel_t                   channel_2,
    output sfd_pkg::channel_t                   channel_3,
    output sfd_pkg::channel_t                   channel_4,
    output sfd_pkg::channel_t                   channel_5,
    output sfd_pkg::channel_t                   channel_6,
    output sfd_pkg::channel_t                   channel_7,
    output logic                                failsafe,
    output logic                                frame_lost
);

    import sfd_pkg::*;

    byte_t    start_byte_reg;
    byte_t    end_byte_reg;
    logic     locked_reg;
    logic     locked_next;
    pos_t     frame_pos_reg;
    pos_t     frame_pos_next;
    byte_t    prev_byte_reg;
    byte_t    data_reg [DATA_COUNT];

    logic     out_valid_reg;
    logic     out_valid_next;
    channel_t channel_reg [CHANNELS];
    logic     failsafe_reg;
    logic     frame_lost_reg;

    logic                       in_accept;
    logic                       out_accept;
    pos_t                       pos_cur;
    logic                       data_we;
    logic [DATA_IDX_W-1:0]      data_idx;
    logic                       emit;
    logic [DATA_COUNT*BYTE_W-1:0] data_bits;

    assign in_ready   = !out_valid_reg || out_ready;
    assign cfg_ready  = 1'b1;
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid_reg && out_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            end_byte_reg   <= END_BYTE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_START_BYTE)
            begin
                start_byte_reg <= cfg_data;
            end
            if (cfg_index == CFG_END_BYTE)
            begin
                end_byte_reg <= cfg_data;
            end
        end
    end

    // frame tracking
    always_comb
    begin
        pos_cur        = (frame_pos_reg >= POS_W'(FRAME_BYTES)) ? '0 : frame_pos_reg;
        locked_next    = locked_reg;
        frame_pos_next = frame_pos_reg;
        data_we        = 1'b0;
        data_idx       = DATA_IDX_W'(pos_cur - POS_W'(1));
        emit           = 1'b0;
        if (!locked_reg)
        begin
            if (rx_byte == start_byte_reg && prev_byte_reg == end_byte_reg)
            begin
                locked_next    = 1'b1;
                frame_pos_next = POS_W'(1);
            end
        end
        else
        begin
            data_we = (pos_cur >= POS_W'(1)) && (pos_cur <= POS_W'(DATA_COUNT));
            emit    = (pos_cur == POS_W'(FLAGS_POS));
            if (pos_cur == POS_W'(FRAME_BYTES - 1))
            begin
                frame_pos_next = '0;
            end
            else
            begin
                frame_pos_next = pos_cur + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg    <= 1'b0;
            frame_pos_reg <= '0;
            prev_byte_reg <= '0;
        end
        else if (in_accept)
        begin
            locked_reg    <= locked_next;
            frame_pos_reg <= frame_pos_next;
            prev_byte_reg <= rx_byte;
        end
    end

    // data byte store
    always_ff @(posedge clk)
    begin
        if (in_accept && data_we)
        begin
            data_reg[data_idx] <= rx_byte;
        end
    end

    // little-endian bit string of data bytes
    always_comb
    begin
        for (int i = 0; i < DATA_COUNT; i++)
        begin
            data_bits[i*BYTE_W +: BYTE_W] = data_reg[i];
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                channel_reg[k] <= data_bits[k*CHAN_W +: CHAN_W];
            end
            failsafe_reg   <= rx_byte[FAILSAFE_BIT];
            frame_lost_reg <= rx_byte[FRAME_LOST_BIT];
        end
    end

    assign out_valid  = out_valid_reg;
    assign channel_0  = channel_reg[0];
    assign channel_1  = channel_reg[1];
    assign channel_2  = channel_reg[2];
    assign channel_3  = channel_reg[3];
    assign channel_4  = channel_reg[4];
    assign channel_5  = channel_reg[5];
    assign channel_6  = channel_reg[6];
    assign channel_7  = channel_reg[7];
    assign failsafe   = failsafe_reg;
    assign frame_lost = frame_lost_reg;

endmodule

`default_nettype wire

FILE: rtl/sfd_checker.sv
// port-level checker for the sbus frame decoder, bound to the top level
`default_nettype none

`include "sbus_frame_decoder_core_assert.svh"

module sfd_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire sfd_pkg::channel_t channel_0
);

    import sfd_pkg::*;

    // a stalled result holds
    `SFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(channel_0))
    // input stalls whenever a result waits
    `SFD_ASSERT_SAME(a_in_stall, out_valid && !out_ready, !in_ready)
    // a new result follows an accepted byte
    `SFD_ASSERT_SAME(a_out_source, $rose(out_valid), $past(in_valid && in_ready))
    // frames are far apart, so results never come in consecutive cycles
    `SFD_ASSERT_NEXT(a_out_spacing, out_valid && out_ready, !out_valid)

endmodule

bind sbus_frame_decoder_core sfd_checker u_sfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel_0 (channel_0)
);

`default_nettype wire

FILE: tb/sv/sbus_frame_checker.sv
`timescale 1ns / 100ps
// frame predictor and result comparator for the sbus frame decoder testbench
module sbus_frame_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  sfd_pkg::byte_t                      rx_byte,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  sfd_pkg::byte_t                      cfg_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  sfd_pkg::channel_t                   channel_0,
    input  sfd_pkg::channel_t                   channel_1,
    input  sfd_pkg::channel_t                   channel_2,
    input  sfd_pkg::channel_t                   channel_3,
    input  sfd_pkg::channel_t                   channel_4,
    input  sfd_pkg::channel_t                   channel_5,
    input  sfd_pkg::channel_t                   channel_6,
    input  sfd_pkg::channel_t                   channel_7,
    input  logic                                failsafe,
    input  logic                                frame_lost,
    output int                                  mismatches,
    output int                                  outstanding,
    output int                                  decoded
);

    typedef struct packed {
        sfd_pkg::channel_t [sfd_pkg::CHANNELS-1:0] chan;
        logic                                      failsafe;
        logic                                      frame_lost;
    } frame_result_t;

    frame_result_t  expected_frames [$];
    sfd_pkg::byte_t start_reg;
    sfd_pkg::byte_t end_reg;
    sfd_pkg::byte_t prev_byte;
    logic           is_locked;
    sfd_pkg::pos_t  frame_pos;
    sfd_pkg::byte_t frame_data [sfd_pkg::DATA_COUNT];
    int             fail_cnt;
    int             decode_cnt;

    function void write_reg(input logic [sfd_pkg::CFG_INDEX_W-1:0] idx,
                            input sfd_pkg::byte_t value);
        if (idx == sfd_pkg::CFG_START_BYTE)
            start_reg = value;
        else if (idx == sfd_pkg::CFG_END_BYTE)
            end_reg = value;
    endfunction

    function void absorb_byte(input sfd_pkg::byte_t b);
        logic [sfd_pkg::DATA_COUNT*sfd_pkg::BYTE_W-1:0] bits;
        frame_result_t                                  r;
        int                                             i;
        if (!is_locked)
        begin
            if (b == start_reg && prev_byte == end_reg)
            begin
                is_locked = 1'b1;
                frame_pos = sfd_pkg::pos_t'(1);
            end
        end
        else
        begin
            if (frame_pos >= 1 && frame_pos <= sfd_pkg::DATA_COUNT)
                frame_data[sfd_pkg::DATA_IDX_W'(frame_pos - 1'b1)] = b;
            if (frame_pos == sfd_pkg::FLAGS_POS)
            begin
                // data bytes 1..11 form one little-endian bit string
                for (i = 0; i < sfd_pkg::DATA_COUNT; i++)
                    bits[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = frame_data[i];
                for (i = 0; i < sfd_pkg::CHANNELS; i++)
                    r.chan[i] = bits[i*sfd_pkg::CHAN_W +: sfd_pkg::CHAN_W];
                r.failsafe   = b[sfd_pkg::FAILSAFE_BIT];
                r.frame_lost = b[sfd_pkg::FRAME_LOST_BIT];
                expected_frames.push_back(r);
            end
            frame_pos = (frame_pos == sfd_pkg::FRAME_BYTES - 1) ? '0 : frame_pos + 1'b1;
        end
        prev_byte = b;
    endfunction

    function void check_frame();
        frame_result_t     want;
        sfd_pkg::channel_t got [sfd_pkg::CHANNELS];
        int                k;
        got = '{channel_0, channel_1, channel_2, channel_3,
                channel_4, channel_5, channel_6, channel_7};
        if (expected_frames.size() == 0)
        begin
            $error("decoded frame transaction with no frame expected");
            fail_cnt++;
            return;
        end
        want = expected_frames.pop_front();
        decode_cnt++;
        for (k = 0; k < sfd_pkg::CHANNELS; k++)
        begin
            if (got[k] !== want.chan[k])
            begin
                $error("channel_%0d expected %0d got %0d", k, want.chan[k], got[k]);
                fail_cnt++;
            end
        end
        if (failsafe !== want.failsafe)
        begin
            $error("failsafe expected %0d got %0d", want.failsafe, failsafe);
            fail_cnt++;
        end
        if (frame_lost !== want.frame_lost)
        begin
            $error("frame_lost expected %0d got %0d", want.frame_lost, frame_lost);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_frames.delete();
            start_reg   = sfd_pkg::START_BYTE_RESET;
            end_reg     = sfd_pkg::END_BYTE_RESET;
            prev_byte   = '0;
            is_locked   = 1'b0;
            frame_pos   = '0;
            fail_cnt    = 0;
            decode_cnt  = 0;
            mismatches  <= 0;
            outstanding <= 0;
            decoded     <= 0;
        end
        else
        begin
            // results leave before the byte of this edge can add one
            if (out_valid && out_ready)
                check_frame();
            // a byte of this edge still sees the old register values
            if (in_valid && in_ready)
                absorb_byte(rx_byte);
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            mismatches  <= fail_cnt;
            outstanding <= expected_frames.size();
            decoded     <= decode_cnt;
        end
    end

endmodule

FILE: tb/sv/sbus_frame_decoder_core_tb.sv
`timescale 1ns / 100ps
// testbench top for the sbus frame decoder: stimulus, receiver and verdict
module sbus_frame_decoder_core_tb;

    localparam logic [sfd_pkg::CFG_INDEX_W-1:0] CFG_NO_REG = 8'hFF;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_AFTER  = 10;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int PHASES           = 4;
    localparam int FRAMES_PER_PHASE = 12;

    typedef enum int {FILL_ONES, FILL_ZEROS, FILL_RANDOM, FILL_CHECKER, FILL_WALK} fill_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    sfd_pkg::byte_t                  rx_byte;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index;
    sfd_pkg::byte_t                  cfg_data;
    logic                            out_valid;
    logic                            out_ready;
    sfd_pkg::channel_t               channel_0;
    sfd_pkg::channel_t               channel_1;
    sfd_pkg::channel_t               channel_2;
    sfd_pkg::channel_t               channel_3;
    sfd_pkg::channel_t               channel_4;
    sfd_pkg::channel_t               channel_5;
    sfd_pkg::channel_t               channel_6;
    sfd_pkg::channel_t               channel_7;
    logic                            failsafe;
    logic                            frame_lost;

    int                              mismatches;
    int                              outstanding;
    int                              decoded;
    int                              bytes_sent;
    int                              reg_writes;
    bit                              sender_steady;
    sfd_pkg::byte_t                  cur_start;
    sfd_pkg::byte_t                  cur_end;

    sbus_frame_decoder_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .channel_0  (channel_0),
        .channel_1  (channel_1),
        .channel_2  (channel_2),
        .channel_3  (channel_3),
        .channel_4  (channel_4),
        .channel_5  (channel_5),
        .channel_6  (channel_6),
        .channel_7  (channel_7),
        .failsafe   (failsafe),
        .frame_lost (frame_lost)
    );

    sbus_frame_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel_0   (channel_0),
        .channel_1   (channel_1),
        .channel_2   (channel_2),
        .channel_3   (channel_3),
        .channel_4   (channel_4),
        .channel_5   (channel_5),
        .channel_6   (channel_6),
        .channel_7   (channel_7),
        .failsafe    (failsafe),
        .frame_lost  (frame_lost),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .decoded     (decoded)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("sbus_frame_decoder_core: mismatch");
        $finish;
    end

    task automatic send_byte(input sfd_pkg::byte_t b);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [sfd_pkg::CFG_INDEX_W-1:0] idx,
                             input sfd_pkg::byte_t value, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (!hold)
            cfg_valid <= 1'b0;
        if (idx == sfd_pkg::CFG_START_BYTE)
            cur_start = value;
        else if (idx == sfd_pkg::CFG_END_BYTE)
            cur_end = value;
        reg_writes++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input sfd_pkg::byte_t start_val, input sfd_pkg::byte_t end_val);
        cfg_write(sfd_pkg::CFG_START_BYTE, start_val, 1'b1);
        cfg_write(sfd_pkg::CFG_END_BYTE, end_val, 1'b0);
    endtask

    function automatic sfd_pkg::byte_t filler_byte();
        unique case ($urandom_range(0, 3))
            0:       return cur_start;
            1:       return cur_end;
            default: return sfd_pkg::byte_t'($urandom);
        endcase
    endfunction

    // one 25 byte frame, position 0 skipped when the lock byte already stood there
    task automatic send_frame(input fill_mode_t mode, input sfd_pkg::byte_t flags,
                              input bit skip_first);
        logic [sfd_pkg::DATA_COUNT*sfd_pkg::BYTE_W-1:0] bits;
        sfd_pkg::byte_t                                 frame_buf [sfd_pkg::FRAME_BYTES];
        int                                             i;
        unique case (mode)
            FILL_ONES:    bits = '1;
            FILL_ZEROS:   bits = '0;
            FILL_CHECKER: bits = {sfd_pkg::DATA_COUNT{(i % 2) ? 8'h55 : 8'hAA}};
            FILL_WALK:
            begin
                bits = '0;
                bits[$urandom_range(0, sfd_pkg::DATA_COUNT*sfd_pkg::BYTE_W - 1)] = 1'b1;
            end
            default:
            begin
                for (i = 0; i < sfd_pkg::DATA_COUNT; i++)
                    bits[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = sfd_pkg::byte_t'($urandom);
            end
        endcase
        if (mode == FILL_CHECKER && $urandom_range(0, 1))
            bits = ~bits;
        for (i = 0; i < sfd_pkg::FRAME_BYTES; i++)
            frame_buf[i] = filler_byte();
        for (i = 0; i < sfd_pkg::DATA_COUNT; i++)
            frame_buf[i + 1] = bits[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W];
        frame_buf[sfd_pkg::FLAGS_POS] = flags;
        for (i = skip_first ? 1 : 0; i < sfd_pkg::FRAME_BYTES; i++)
            send_byte(frame_buf[i]);
    endtask

    // receiver: random per result stalls, with one long hold-off
    initial
    begin : receiver
        int gap;
        int taken;
        out_ready = 1'b0;
        taken     = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = ((taken % 8) < 3) ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (gap - 1) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            if (taken == LONG_HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int p;
        int f;
        in_valid      = 1'b0;
        rx_byte       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        bytes_sent    = 0;
        reg_writes    = 0;
        sender_steady = 1'b0;
        cur_start     = sfd_pkg::START_BYTE_RESET;
        cur_end       = sfd_pkg::END_BYTE_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write to an unmapped index must change nothing
        cfg_write(CFG_NO_REG, 8'h37, 1'b1);
        set_regs(8'hFF, 8'h00);

        // hunt: start without end, end without start, then a proper pair
        send_byte(8'h37);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h12);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(FILL_ONES, 8'h08, 1'b1);

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            unique case (p)
                0:       set_regs(8'h00, 8'hFF);
                1:       set_regs(sfd_pkg::byte_t'($urandom), sfd_pkg::byte_t'($urandom));
                2:       set_regs(sfd_pkg::START_BYTE_RESET, sfd_pkg::END_BYTE_RESET);
                default: set_regs(8'hFF, 8'hFF);
            endcase
            for (f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                sender_steady = (f % 4 == 0);
                send_frame(fill_mode_t'($urandom_range(FILL_ONES, FILL_WALK)),
                           sfd_pkg::byte_t'($urandom), 1'b0);
            end
            sender_steady = 1'b0;
        end

        drain();
        $display("%0d bytes sent, %0d frames decoded, %0d register writes",
                 bytes_sent, decoded, reg_writes);
        $display("covered hunting, lock, all fill patterns, flag bits and a long output stall");
        if (mismatches == 0 && outstanding == 0)
            $display("sbus_frame_decoder_core: match");
        else
            $display("sbus_frame_decoder_core: mismatch");
        $finish;
    end

endmodule
